// ----- sv/dpc_pkg.sv -----
// Shared types, register indexes and constants of the depth pixel colouriser.
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  localparam int DEPTH_W = 13;
  localparam int SPEED_W = 16;
  localparam int FACTOR_W = 9;
  localparam int PLAYER_W = 3;
  localparam int INDEX_W = 3;
  localparam int DATA_W = 16;

  localparam logic [INDEX_W-1:0] REG_HAND_SPEED_SUM = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SPEED_FACTOR = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SCALE_LOW = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SCALE_HIGH = 3'd3;
  localparam logic [INDEX_W-1:0] REG_EFFECT_ON = 3'd4;
  localparam logic [INDEX_W-1:0] REG_LEFT_FORWARD = 3'd5;
  localparam logic [INDEX_W-1:0] REG_RIGHT_FORWARD = 3'd6;
  localparam logic [INDEX_W-1:0] REG_INVALID_PLAYER = 3'd7;

  localparam logic [FACTOR_W-1:0] SPEED_FACTOR_RESET = 9'd102;
  localparam logic [FACTOR_W-1:0] SCALE_LOW_RESET = 9'd51;
  localparam logic [FACTOR_W-1:0] SCALE_HIGH_RESET = 9'd256;

  // Division of 256 * depth by 4095 uses the reciprocal 2^24 / 4095 rounded down.
  localparam logic [12:0] DEPTH_RECIP = 13'd4097;
  localparam logic [21:0] DEPTH_DIVISOR = 22'd4095;
  localparam logic [9:0] QUOT_MAX = 10'd512;
  localparam logic [7:0] LUM_MAX = 8'd255;

  typedef struct packed {
    logic [SPEED_W-1:0]  hand_speed_sum;
    logic [FACTOR_W-1:0] speed_factor;
    logic [FACTOR_W-1:0] scale_low;
    logic [FACTOR_W-1:0] scale_high;
    logic                effect_on;
    logic                left_forward;
    logic                right_forward;
    logic [PLAYER_W-1:0] invalid_player;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          lum;
    logic [PLAYER_W-1:0] player;
    logic [3:0]          nibble;
  } lum_word_t;

endpackage

`default_nettype wire

// ----- sv/dpc_cfg.sv -----
// Configuration register file of the depth pixel colouriser.
`timescale 1ns / 1ps
`default_nettype none

module dpc_cfg
  import dpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]  cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hand_speed_sum <= '0;
      cfg.speed_factor <= SPEED_FACTOR_RESET;
      cfg.scale_low <= SCALE_LOW_RESET;
      cfg.scale_high <= SCALE_HIGH_RESET;
      cfg.effect_on <= 1'b0;
      cfg.left_forward <= 1'b0;
      cfg.right_forward <= 1'b0;
      cfg.invalid_player <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HAND_SPEED_SUM: cfg.hand_speed_sum <= cfg_data[SPEED_W-1:0];
        REG_SPEED_FACTOR: cfg.speed_factor <= cfg_data[FACTOR_W-1:0];
        REG_SCALE_LOW: cfg.scale_low <= cfg_data[FACTOR_W-1:0];
        REG_SCALE_HIGH: cfg.scale_high <= cfg_data[FACTOR_W-1:0];
        REG_EFFECT_ON: cfg.effect_on <= cfg_data[0];
        REG_LEFT_FORWARD: cfg.left_forward <= cfg_data[0];
        REG_RIGHT_FORWARD: cfg.right_forward <= cfg_data[0];
        REG_INVALID_PLAYER: cfg.invalid_player <= cfg_data[PLAYER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/dpc_luma.sv -----
// Three-stage luminance pipeline: depth division, brightness clamp, scaling.
`timescale 1ns / 1ps
`default_nettype none

module dpc_luma
  import dpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] in_word,
  output logic                   lum_valid,
  input  wire logic              lum_ready,
  output lum_word_t              lum_word
);

  logic                s1_valid;
  logic                s1_ready;
  logic [DEPTH_W-1:0]  s1_depth;
  logic [9:0]          s1_qe;
  logic [24:0]         s1_speed;
  logic [PLAYER_W-1:0] s1_player;
  logic [3:0]          s1_nibble;

  logic                s2_valid;
  logic                s2_ready;
  logic [7:0]          s2_base;
  logic [8:0]          s2_scale;
  logic [PLAYER_W-1:0] s2_player;
  logic [3:0]          s2_nibble;

  logic                s3_valid;
  logic                s3_ready;
  logic [7:0]          s3_lum;
  logic [PLAYER_W-1:0] s3_player;
  logic [3:0]          s3_nibble;

  logic [DEPTH_W-1:0]  depth;
  logic [25:0]         recip_prod;
  logic [24:0]         speed_prod;
  logic [21:0]         dividend;
  logic [21:0]         qe_times_div;
  logic [21:0]         remainder;
  logic [7:0]          quot_lo;
  logic [16:0]         scale_raw;
  logic [8:0]          scale_clamped;
  logic [16:0]         lum_prod;
  logic [7:0]          lum_sat;

  assign s3_ready = !s3_valid || lum_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign depth = in_word[DATA_W-1:3];
  assign recip_prod = depth * DEPTH_RECIP;
  assign speed_prod = cfg.hand_speed_sum * cfg.speed_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_depth <= depth;
      s1_qe <= recip_prod[25:16];
      s1_speed <= speed_prod;
      s1_player <= in_word[PLAYER_W-1:0];
      s1_nibble <= in_word[7:4];
    end
  end

  // The reciprocal estimate is the true quotient or one below it.
  assign dividend = {1'b0, s1_depth, 8'd0};
  assign qe_times_div = {s1_qe, 12'd0} - {12'd0, s1_qe};
  assign remainder = dividend - qe_times_div;
  assign quot_lo = s1_qe[7:0] + {7'd0, (remainder >= DEPTH_DIVISOR)};
  assign scale_raw = s1_speed[24:8];

  always_comb begin
    if (scale_raw < {8'd0, cfg.scale_low}) begin
      scale_clamped = cfg.scale_low;
    end else if (scale_raw > {8'd0, cfg.scale_high}) begin
      scale_clamped = cfg.scale_high;
    end else begin
      scale_clamped = scale_raw[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_base <= LUM_MAX - quot_lo;
      s2_scale <= scale_clamped;
      s2_player <= s1_player;
      s2_nibble <= s1_nibble;
    end
  end

  assign lum_prod = s2_base * s2_scale;
  assign lum_sat = lum_prod[16] ? LUM_MAX : lum_prod[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      s3_lum <= lum_sat;
      s3_player <= s2_player;
      s3_nibble <= s2_nibble;
    end
  end

  assign lum_valid = s3_valid;
  assign lum_word.lum = s3_lum;
  assign lum_word.player = s3_player;
  assign lum_word.nibble = s3_nibble;

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_qe <= QUOT_MAX))
    else $error("depth quotient estimate out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_depth) && $stable(s1_qe)))
    else $error("stalled first stage lost its word");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !lum_ready) |=> (s3_valid && $stable(s3_lum) && $stable(s3_player)))
    else $error("stalled luminance stage lost its word");

endmodule

`default_nettype wire

// ----- sv/dpc_colour.sv -----
// Output stage: player colour table or effect colouring into a result register.
`timescale 1ns / 1ps
`default_nettype none

module dpc_colour
  import dpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       lum_valid,
  output logic            lum_ready,
  input  wire lum_word_t  lum_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic [7:0] l;
  logic [7:0] half;
  logic [7:0] quarter;
  logic [7:0] v;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  assign l = lum_word.lum;
  assign half = {1'b0, l[7:1]};
  assign quarter = {2'b00, l[7:2]};
  assign v = {lum_word.nibble, 4'd0};
  assign lum_ready = !out_valid || out_ready;

  always_comb begin
    red_next = '0;
    green_next = '0;
    blue_next = '0;
    if (cfg.effect_on && (lum_word.player != cfg.invalid_player)) begin
      if (cfg.left_forward && cfg.right_forward) begin
        red_next = v;
        green_next = v;
      end else if (cfg.left_forward) begin
        red_next = v;
      end else if (cfg.right_forward) begin
        green_next = v;
      end else begin
        red_next = v;
        green_next = v;
        blue_next = v;
      end
    end else begin
      case (lum_word.player)
        3'd0: begin
          red_next = half;
          green_next = half;
          blue_next = half;
        end
        3'd1: red_next = l;
        3'd2: green_next = l;
        3'd3: begin
          red_next = quarter;
          green_next = l;
          blue_next = l;
        end
        3'd4: begin
          red_next = l;
          green_next = l;
          blue_next = quarter;
        end
        3'd5: begin
          red_next = l;
          green_next = quarter;
          blue_next = l;
        end
        3'd6: begin
          red_next = half;
          green_next = half;
          blue_next = l;
        end
        default: begin
          red_next = LUM_MAX - half;
          green_next = LUM_MAX - half;
          blue_next = LUM_MAX - half;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lum_ready) begin
      out_valid <= lum_valid;
    end
    if (lum_ready && lum_valid) begin
      red <= red_next;
      green <= green_next;
      blue <= blue_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/depth_player_pixel_colorizer.sv -----
// Top level of the depth pixel colouriser: registers, luminance pipeline, output stage.
//
// One 16-bit depth word goes in on the in_valid/in_ready channel (bits 15:3
// depth, bits 2:0 player index) and one red/green/blue word comes out on the
// out_valid/out_ready channel for each word taken.
// The pipeline has four register stages: divide estimate and speed product,
// quotient correction and brightness clamp, luminance multiply, then the
// colour table into the result register. One word is taken in every cycle
// while the receiver keeps out_ready high, since each stage hands its word
// on whenever the stage after it is free or emptying.
// When the receiver holds out_ready low, each stage keeps its word and the
// stages behind it keep filling until the pipeline is full, then in_ready
// falls; nothing is dropped or repeated.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user is to make writes only while
// no word is in flight; the block does not enforce this. A synchronous reset
// empties the pipeline and restores the register defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module depth_player_pixel_colorizer
  import dpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [DATA_W-1:0]  depth_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  cfg_t      cfg;
  logic      lum_valid;
  logic      lum_ready;
  lum_word_t lum_word;

  dpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpc_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (depth_word),
    .lum_valid (lum_valid),
    .lum_ready (lum_ready),
    .lum_word  (lum_word)
  );

  dpc_colour u_colour (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .lum_valid (lum_valid),
    .lum_ready (lum_ready),
    .lum_word  (lum_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire
